// File: hdl/cpualu_pkg.sv
// shared types and constants for the 8/16-bit cpu alu with flags
// no dependencies; imported by cpualu_core and cpu_alu_with_flags
package cpualu_pkg;

  localparam int unsigned MODE_W = 5;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 5'd0,
    MODE_ADC   = 5'd1,
    MODE_SUB   = 5'd2,
    MODE_SBC   = 5'd3,
    MODE_AND   = 5'd4,
    MODE_XOR   = 5'd5,
    MODE_OR    = 5'd6,
    MODE_CP    = 5'd7,
    MODE_INC   = 5'd8,
    MODE_DEC   = 5'd9,
    MODE_RLCA  = 5'd10,
    MODE_RLA   = 5'd11,
    MODE_RRCA  = 5'd12,
    MODE_RRA   = 5'd13,
    MODE_DAA   = 5'd14,
    MODE_CPL   = 5'd15,
    MODE_SCF   = 5'd16,
    MODE_CCF   = 5'd17,
    MODE_ADD16 = 5'd18,
    MODE_INC16 = 5'd19,
    MODE_DEC16 = 5'd20
  } mode_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // decimal adjust constants, and the all-ones nibble used by the increment half-carry test
  localparam logic [BYTE_W-1:0] DAA_LIMIT   = 8'h99;
  localparam logic [BYTE_W-1:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [BYTE_W-1:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [3:0]        DAA_NIB_MAX = 4'h9;
  localparam logic [3:0]        NIB_ALL     = 4'hF;

endpackage

// File: hdl/cpu_alu_with_flags.sv
// top level of the 8/16-bit cpu alu with z/n/h/c flags
// depends on cpualu_pkg and cpualu_core
//
// The block takes one operation per transaction (mode, two 16-bit operands
// and the current z/n/h/c flags) and returns one result transaction with the
// new register value and the new flags. An accepted transaction passes through
// an input register that feeds the combinational alu core, whose value and
// flags land in the output register. Throughput is one transaction per cycle;
// both stages advance whenever the stage after them is empty or being drained,
// so a new transaction can enter an empty input stage while a finished one
// still waits on out_ready. 8-bit modes work on the low operand bytes and
// return zero in the upper result byte; compare, scf, ccf and unused mode codes
// return the first operand unchanged.
module cpu_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_mode,
  input  logic [15:0] in_first_operand,
  input  logic [15:0] in_second_operand,
  input  logic        in_zero_in,
  input  logic        in_subtract_in,
  input  logic        in_half_in,
  input  logic        in_carry_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  output logic        out_zero_out,
  output logic        out_subtract_out,
  output logic        out_half_out,
  output logic        out_carry_out
);
  import cpualu_pkg::*;

  // input stage registers
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  mode_t       s1_mode_r;
  logic [15:0] s1_x_r;
  logic [15:0] s1_y_r;
  flags_t      s1_flags_r;

  // output stage registers
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] out_result_r;
  flags_t      out_flags_r;

  // core results
  logic [15:0] core_result;
  flags_t      core_flags;

  // stage handshakes
  logic out_free;   // output register can take a new transaction
  logic s1_go;      // input stage hands its transaction to the output stage
  logic in_take;    // input transaction accepted this cycle

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && !out_ready);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= mode_t'(in_mode);
      s1_x_r     <= in_first_operand;
      s1_y_r     <= in_second_operand;
      s1_flags_r <= '{z: in_zero_in, n: in_subtract_in, h: in_half_in, c: in_carry_in};
    end
  end

  cpualu_core u_core (
    .mode      (s1_mode_r),
    .x16       (s1_x_r),
    .y16       (s1_y_r),
    .flags_in  (s1_flags_r),
    .result    (core_result),
    .flags_out (core_flags)
  );

  // result payload capture; held while the consumer stalls
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_result_r <= core_result;
      out_flags_r  <= core_flags;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_zero_out     = out_flags_r.z;
  assign out_subtract_out = out_flags_r.n;
  assign out_half_out     = out_flags_r.h;
  assign out_carry_out    = out_flags_r.c;

  // an accepted transaction always lands in the input stage
  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted transaction did not reach input stage");

  // a stage handoff always produces a valid result
  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("stage handoff lost a result");

  // a blocked input stage keeps its transaction
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_x_r) && $stable(s1_mode_r)))
    else $error("input stage dropped a stalled transaction");

  // compare leaves the first operand untouched
  a_cp_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_mode_r == MODE_CP)) |=> (out_result_r == $past(s1_x_r)))
    else $error("compare altered the first operand");

endmodule

// File: hdl/cpualu_core.sv
// combinational alu datapath: one operation and its new flags
// depends on cpualu_pkg
module cpualu_core (
  input  cpualu_pkg::mode_t  mode,
  input  logic [15:0]        x16,
  input  logic [15:0]        y16,
  input  cpualu_pkg::flags_t flags_in,
  output logic [15:0]        result,
  output cpualu_pkg::flags_t flags_out
);
  import cpualu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin_add;
  logic        cin_sub;
  logic [8:0]  sum9;
  logic [4:0]  sum_nib;
  logic [8:0]  diff9;
  logic [4:0]  diff_nib;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0]  daa_r;
  logic        daa_c;
  logic [7:0]  r8;

  assign a = x16[7:0];
  assign b = y16[7:0];

  assign cin_add = (mode == MODE_ADC) ? flags_in.c : 1'b0;
  assign cin_sub = (mode == MODE_SBC) ? flags_in.c : 1'b0;

  assign sum9     = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
  assign sum_nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
  // borrow shows up as the top bit of the extended difference
  assign diff9    = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
  assign diff_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};
  assign sum17    = {1'b0, x16} + {1'b0, y16};
  assign sum13    = {1'b0, x16[11:0]} + {1'b0, y16[11:0]};

  // decimal adjust after add or subtract
  always_comb begin
    daa_r = a;
    daa_c = flags_in.c;
    if (!flags_in.n) begin
      if (flags_in.c || (a > DAA_LIMIT)) begin
        daa_r = daa_r + DAA_HI_ADJ;
        daa_c = 1'b1;
      end
      if (flags_in.h || (a[3:0] > DAA_NIB_MAX)) begin
        daa_r = daa_r + DAA_LO_ADJ;
      end
    end else begin
      if (flags_in.c) begin
        daa_r = daa_r - DAA_HI_ADJ;
      end
      if (flags_in.h) begin
        daa_r = daa_r - DAA_LO_ADJ;
      end
    end
  end

  always_comb begin
    r8        = 8'd0;
    result    = x16;
    flags_out = flags_in;
    case (mode)
      MODE_ADD, MODE_ADC: begin
        r8        = sum9[7:0];
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: sum_nib[4], c: sum9[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        r8        = diff9[7:0];
        result    = (mode == MODE_CP) ? x16 : {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b1, h: diff_nib[4], c: diff9[8]};
      end
      MODE_AND: begin
        r8        = a & b;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      MODE_XOR: begin
        r8        = a ^ b;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_OR: begin
        r8        = a | b;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_INC: begin
        r8        = a + 8'd1;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: (a[3:0] == NIB_ALL), c: flags_in.c};
      end
      MODE_DEC: begin
        r8        = a - 8'd1;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'd0), c: flags_in.c};
      end
      MODE_RLCA: begin
        r8        = {a[6:0], a[7]};
        result    = {8'd0, r8};
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      MODE_RLA: begin
        r8        = {a[6:0], flags_in.c};
        result    = {8'd0, r8};
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      MODE_RRCA: begin
        r8        = {a[0], a[7:1]};
        result    = {8'd0, r8};
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_RRA: begin
        r8        = {flags_in.c, a[7:1]};
        result    = {8'd0, r8};
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_DAA: begin
        r8        = daa_r;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
      end
      MODE_CPL: begin
        r8        = ~a;
        result    = {8'd0, r8};
        flags_out = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
      end
      MODE_SCF: begin
        flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      MODE_CCF: begin
        flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~flags_in.c};
      end
      MODE_ADD16: begin
        result    = sum17[15:0];
        flags_out = '{z: flags_in.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      MODE_INC16: begin
        result = x16 + 16'd1;
      end
      MODE_DEC16: begin
        result = x16 - 16'd1;
      end
      default: begin
        // unused codes pass the operand and flags through
        result    = x16;
        flags_out = flags_in;
      end
    endcase
  end

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for cpu_alu_with_flags: directed corners, random mixes, back-pressure
// depends on cpualu_pkg (mode codes) and the cpu_alu_with_flags rtl; needs nothing else
module tb_top;
  import cpualu_pkg::*;

  // mode codes the block treats as no operation
  localparam logic [4:0] MODE_SPARE_FIRST = 5'd21;
  localparam logic [4:0] MODE_SPARE_LAST  = 5'd31;
  // two-stage pipe, so the extra drain wait covers anything still in flight
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int RUN_LIMIT    = 4_000_000;

  // one operation as offered on the input channel
  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] a16;
    logic [15:0] b16;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
  } alu_op_t;

  // register value and flags the block should return
  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] value;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
  } alu_res_t;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [4:0]  in_mode           = '0;
  logic [15:0] in_first_operand  = '0;
  logic [15:0] in_second_operand = '0;
  logic        in_zero_in        = 1'b0;
  logic        in_subtract_in    = 1'b0;
  logic        in_half_in        = 1'b0;
  logic        in_carry_in       = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [15:0] out_result;
  logic        out_zero_out;
  logic        out_subtract_out;
  logic        out_half_out;
  logic        out_carry_out;

  // results predicted for accepted transactions, oldest first
  alu_res_t    pending_results[$];
  alu_res_t    want;
  int          mismatches         = 0;
  int          sent_count         = 0;
  int          checked_count      = 0;
  int          backpressure_cycles = 0;
  int          send_idle_pct      = 0;
  int          recv_stall_pct     = 0;
  int          hold_left          = 0;
  logic [31:0] modes_seen         = '0;

  cpu_alu_with_flags u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_first_operand  (in_first_operand),
    .in_second_operand (in_second_operand),
    .in_zero_in        (in_zero_in),
    .in_subtract_in    (in_subtract_in),
    .in_half_in        (in_half_in),
    .in_carry_in       (in_carry_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result        (out_result),
    .out_zero_out      (out_zero_out),
    .out_subtract_out  (out_subtract_out),
    .out_half_out      (out_half_out),
    .out_carry_out     (out_carry_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous wall for a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  // expected value and flags of one operation
  function automatic alu_res_t alu_predict(alu_op_t op);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic        cin;
    alu_res_t    res;
    a = op.a16[7:0];
    b = op.b16[7:0];
    // default covers the spare codes: everything passes through
    res.mode  = op.mode;
    res.value = op.a16;
    res.z     = op.z;
    res.n     = op.n;
    res.h     = op.h;
    res.c     = op.c;
    case (op.mode)
      MODE_ADD, MODE_ADC: begin
        cin   = (op.mode == MODE_ADC) ? op.c : 1'b0;
        sum9  = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        res.value = {8'h00, sum9[7:0]};
        res.z = (sum9[7:0] == 8'h00);
        res.n = 1'b0;
        res.h = nib[4];
        res.c = sum9[8];
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        // compare keeps the whole first operand but takes the sub flags
        cin = (op.mode == MODE_SBC) ? op.c : 1'b0;
        r   = a - b - {7'h00, cin};
        res.value = (op.mode == MODE_CP) ? op.a16 : {8'h00, r};
        res.z = (r == 8'h00);
        res.n = 1'b1;
        res.h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cin});
        res.c = {1'b0, a} < ({1'b0, b} + {8'h00, cin});
      end
      MODE_AND: begin
        r = a & b;
        res.value = {8'h00, r};
        res.z = (r == 8'h00);
        res.n = 1'b0;
        res.h = 1'b1;
        res.c = 1'b0;
      end
      MODE_XOR, MODE_OR: begin
        r = (op.mode == MODE_XOR) ? (a ^ b) : (a | b);
        res.value = {8'h00, r};
        res.z = (r == 8'h00);
        res.n = 1'b0;
        res.h = 1'b0;
        res.c = 1'b0;
      end
      MODE_INC: begin
        r = a + 8'h01;
        res.value = {8'h00, r};
        res.z = (r == 8'h00);
        res.n = 1'b0;
        res.h = (a[3:0] == 4'hF);
      end
      MODE_DEC: begin
        r = a - 8'h01;
        res.value = {8'h00, r};
        res.z = (r == 8'h00);
        res.n = 1'b1;
        res.h = (a[3:0] == 4'h0);
      end
      MODE_RLCA, MODE_RLA, MODE_RRCA, MODE_RRA: begin
        case (op.mode)
          MODE_RLCA: r = {a[6:0], a[7]};
          MODE_RLA:  r = {a[6:0], op.c};
          MODE_RRCA: r = {a[0], a[7:1]};
          default:   r = {op.c, a[7:1]};
        endcase
        res.value = {8'h00, r};
        res.z = 1'b0;
        res.n = 1'b0;
        res.h = 1'b0;
        res.c = (op.mode == MODE_RLCA || op.mode == MODE_RLA) ? a[7] : a[0];
      end
      MODE_DAA: begin
        r = a;
        if (!op.n) begin
          if (op.c || a > 8'h99) begin
            r     = r + 8'h60;
            res.c = 1'b1;
          end
          if (op.h || a[3:0] > 4'h9) r = r + 8'h06;
        end else begin
          if (op.c) r = r - 8'h60;
          if (op.h) r = r - 8'h06;
        end
        res.value = {8'h00, r};
        res.z = (r == 8'h00);
        res.h = 1'b0;
      end
      MODE_CPL: begin
        res.value = {8'h00, ~a};
        res.n = 1'b1;
        res.h = 1'b1;
      end
      MODE_SCF, MODE_CCF: begin
        res.n = 1'b0;
        res.h = 1'b0;
        res.c = (op.mode == MODE_SCF) ? 1'b1 : ~op.c;
      end
      MODE_ADD16: begin
        sum17 = {1'b0, op.a16} + {1'b0, op.b16};
        sum13 = {1'b0, op.a16[11:0]} + {1'b0, op.b16[11:0]};
        res.value = sum17[15:0];
        res.n = 1'b0;
        res.h = sum13[12];
        res.c = sum17[16];
      end
      MODE_INC16: res.value = op.a16 + 16'h0001;
      MODE_DEC16: res.value = op.a16 - 16'h0001;
      default: ;
    endcase
    return res;
  endfunction

  function automatic alu_op_t make_op(logic [4:0] mode, logic [15:0] a16, logic [15:0] b16,
                                      logic [3:0] znhc);
    alu_op_t op;
    op.mode = mode;
    op.a16  = a16;
    op.b16  = b16;
    {op.z, op.n, op.h, op.c} = znhc;
    return op;
  endfunction

  // biased toward nibble and byte edges where the flags turn over
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v[7:0] = 8'hFF;
      3: v[7:0] = 8'h0F;
      4: v[7:0] = 8'h99;
      5: v[11:0] = 12'hFFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    if ($urandom_range(0, 9) == 0) op.mode = 5'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    else                           op.mode = 5'($urandom_range(MODE_ADD, MODE_DEC16));
    op.a16 = pick_operand();
    op.b16 = pick_operand();
    {op.z, op.n, op.h, op.c} = 4'($urandom);
    return op;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // offer one transaction, idling first at the sender's rate, and hold it until taken
  task automatic send_op(input alu_op_t op);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_mode           <= op.mode;
    in_first_operand  <= op.a16;
    in_second_operand <= op.b16;
    in_zero_in        <= op.z;
    in_subtract_in    <= op.n;
    in_half_in        <= op.h;
    in_carry_in       <= op.c;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_results.push_back(alu_predict(op));
    modes_seen[op.mode] = 1'b1;
    sent_count++;
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_op(random_op());
  endtask

  // receiver: a long hold when asked, otherwise random stalls at the phase's rate
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (in_valid && !in_ready) backpressure_cycles++;
  end

  // result checker: every output transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_result));
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_result !== want.value)
          report_mismatch($sformatf("mode %0d result %h, want %h", want.mode, out_result,
                                    want.value));
        if (out_zero_out !== want.z)
          report_mismatch($sformatf("mode %0d zero %b, want %b", want.mode, out_zero_out,
                                    want.z));
        if (out_subtract_out !== want.n)
          report_mismatch($sformatf("mode %0d subtract %b, want %b", want.mode,
                                    out_subtract_out, want.n));
        if (out_half_out !== want.h)
          report_mismatch($sformatf("mode %0d half %b, want %b", want.mode, out_half_out,
                                    want.h));
        if (out_carry_out !== want.c)
          report_mismatch($sformatf("mode %0d carry %b, want %b", want.mode, out_carry_out,
                                    want.c));
      end
    end
  end

  // every operation at least once at its flag-flipping corners; flags given as {z,n,h,c}
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(make_op(MODE_ADD,   16'h00FF, 16'h0001, 4'b0000)); // zero, half and carry together
    send_op(make_op(MODE_ADC,   16'hFF0F, 16'hFF00, 4'b0001)); // carry in makes the half carry
    send_op(make_op(MODE_SUB,   16'h003C, 16'h003C, 4'b0000)); // equal operands give zero
    send_op(make_op(MODE_SBC,   16'h0000, 16'h0000, 4'b0001)); // borrow through both nibbles
    send_op(make_op(MODE_AND,   16'hFFF0, 16'h000F, 4'b0000)); // zero with half forced high
    send_op(make_op(MODE_XOR,   16'hFFFF, 16'hFFFF, 4'b1111));
    send_op(make_op(MODE_OR,    16'h0000, 16'hFF00, 4'b1111)); // upper bytes ignored
    send_op(make_op(MODE_CP,    16'hAB42, 16'h0043, 4'b0000)); // compare keeps the upper byte
    send_op(make_op(MODE_INC,   16'hFFFF, 16'h0000, 4'b0001)); // wrap to zero, carry kept
    send_op(make_op(MODE_INC,   16'h000F, 16'h0000, 4'b0000));
    send_op(make_op(MODE_DEC,   16'h0000, 16'h0000, 4'b0000)); // borrow from low nibble
    send_op(make_op(MODE_DEC,   16'h0001, 16'h0000, 4'b0001));
    send_op(make_op(MODE_RLCA,  16'h0080, 16'h0000, 4'b1110)); // zero, sub, half all cleared
    send_op(make_op(MODE_RLA,   16'h0080, 16'h0000, 4'b0001));
    send_op(make_op(MODE_RRCA,  16'h0001, 16'h0000, 4'b0000));
    send_op(make_op(MODE_RRA,   16'h0001, 16'h0000, 4'b0001));
    send_op(make_op(MODE_DAA,   16'h009A, 16'h0000, 4'b0000)); // both nibbles adjusted to zero
    send_op(make_op(MODE_DAA,   16'h0000, 16'h0000, 4'b0111)); // after subtract, both adjusts
    send_op(make_op(MODE_DAA,   16'h0015, 16'h0000, 4'b0010));
    send_op(make_op(MODE_CPL,   16'h125A, 16'h0000, 4'b1001)); // zero and carry pass through
    send_op(make_op(MODE_SCF,   16'hBEEF, 16'h0000, 4'b1110));
    send_op(make_op(MODE_CCF,   16'hFFFF, 16'h0000, 4'b0001));
    send_op(make_op(MODE_ADD16, 16'hFFFF, 16'h0001, 4'b1000)); // full carry, zero flag kept
    send_op(make_op(MODE_ADD16, 16'h0FFF, 16'h0001, 4'b0100)); // carry out of bit 11 only
    send_op(make_op(MODE_INC16, 16'hFFFF, 16'hFFFF, 4'b1111)); // flags all kept
    send_op(make_op(MODE_DEC16, 16'h0000, 16'h0000, 4'b0000));
    send_op(make_op(MODE_SPARE_FIRST, 16'h1234, 16'h5678, 4'b1010));
    send_op(make_op(MODE_SPARE_LAST,  16'hFEDC, 16'hBA98, 4'b0101));
  endtask

  task automatic test_random_no_idle();
    run_random(300, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random(250, 80, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random(250, 0, 80);
  endtask

  task automatic test_random_both_idle();
    run_random(250, 24, 24);
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills and stalls
  task automatic test_output_hold();
    hold_left = HOLD_CYCLES;
    run_random(40, 0, 0);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // main sequence: reset once, then each test in turn
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_hold();
    wait_for_drain();
    $display("checked %0d of %0d transactions over %0d mode codes (all operations and spares)",
             checked_count, sent_count, $countones(modes_seen));
    $display("idle and stall mixes up to 80 percent, one %0d-cycle output hold, %0d stalled inputs",
             HOLD_CYCLES, backpressure_cycles);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
